FILE: hw/rtl/assert_macros.svh
// Assertion macros for the priority queue RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
// No dependencies.
package spq_pkg;

    localparam int Depth = 16;
    localparam int DataW = 32;
    localparam int PrioW = 32;
    localparam int CntW  = $clog2(Depth + 1);

    localparam logic ReqInsert  = 1'b0;
    localparam logic ReqExtract = 1'b1;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic [PrioW-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic             ins;
        logic             ext;
        logic [DataW-1:0] value;
        logic [PrioW-1:0] prio;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward either neighbor.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  logic      i_prev_gt,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output t_entry    o_next_entry,
    output logic      o_gt
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_gt;

    // new entry belongs at or before this slot
    assign w_gt = !i_valid || (r_entry.prio > i_ctl.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_gt) begin
                if (i_prev_gt) begin
                    n_entry = i_prev;
                end else begin
                    n_entry.value = i_ctl.value;
                    n_entry.prio  = i_ctl.prio;
                end
            end
        end else if (i_ctl.ext) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_next_entry = n_entry;
    assign o_gt         = w_gt;

endmodule

FILE: hw/rtl/stable_min_priority_queue_top.sv
// Stable min priority queue: chain of sorted cells plus fill count and result register.
// The result beat is registered and presented in the cycle after its request beat is accepted.
// Throughput: one request per cycle unless a held result is not taken; every cell compares
// against the broadcast priority and shifts in the same cycle, and the result register holds each result beat.
// Reset (synchronous, active low) empties the queue and drops any pending result.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
`include "assert_macros.svh"
module stable_min_priority_queue_top
    import spq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // [31:0] in_value, [63:32] in_priority
    input  logic         i_s_tuser,   // [0] req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // [31:0] out_value, [63:32] out_priority,
                                      // [95:64] head_value, [127:96] head_priority
    output logic [2:0]   o_m_tuser    // [0] out_valid, [1] queue_empty, [2] full_drop
);

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_tvalid;
    logic [127:0]    r_tdata;
    logic [2:0]      r_tuser;

    logic      w_fire;
    logic      w_full;
    logic      w_empty;
    logic      w_ins_req;
    t_cell_ctl w_ctl;

    t_entry w_entry [Depth];
    t_entry w_next  [Depth];
    logic   w_gt    [Depth];

    t_entry w_head;
    logic   w_drop;

    assign o_s_tready = !r_tvalid || i_m_tready;
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CntW'(Depth));
    assign w_empty    = (r_count == '0);
    assign w_ins_req  = (i_s_tuser == ReqInsert);

    always_comb begin
        w_ctl.ins   = w_fire && w_ins_req && !w_full;
        w_ctl.ext   = w_fire && (i_s_tuser == ReqExtract) && !w_empty;
        w_ctl.value = DataW'(i_s_tdata[31:0]);
        w_ctl.prio  = i_s_tdata[63:32];
    end

    for (genvar gi = 0; gi < Depth; gi++) begin : g_cell
        t_entry w_prev_e;
        t_entry w_next_e;
        logic   w_prev_gt;

        if (gi == 0) begin : g_first
            assign w_prev_e  = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev_e  = w_entry[gi-1];
            assign w_prev_gt = w_gt[gi-1];
        end

        if (gi == Depth - 1) begin : g_last
            assign w_next_e = '0;
        end else begin : g_inner
            assign w_next_e = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (CntW'(gi) < r_count),
            .i_prev_gt    (w_prev_gt),
            .i_prev       (w_prev_e),
            .i_next       (w_next_e),
            .o_entry      (w_entry[gi]),
            .o_next_entry (w_next[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CntW'(1);
        end else if (w_ctl.ext) begin
            n_count = r_count - CntW'(1);
        end
    end

    assign w_head = (n_count != '0) ? w_next[0] : '0;
    assign w_drop = w_fire && w_ins_req && w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_tvalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_tdata[31:0]   <= w_ctl.ext ? 32'(w_entry[0].value) : 32'd0;
            r_tdata[63:32]  <= w_ctl.ext ? w_entry[0].prio : 32'd0;
            r_tdata[95:64]  <= 32'(w_head.value);
            r_tdata[127:96] <= w_head.prio;
            r_tuser         <= {w_drop, (n_count == '0), w_ctl.ext};
        end
    end

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    `SPQ_ASSERT(a_count_bound, r_count <= CntW'(Depth), "fill count above depth")
    `SPQ_ASSERT_NXT(a_full_drop, w_drop,
        (r_count == $past(r_count)) && o_m_tuser[2], "full insert changed queue")
    `SPQ_ASSERT_NXT(a_empty_extract, w_fire && !w_ins_req && w_empty,
        !o_m_tuser[0] && (r_count == '0), "extract on empty returned data")
    `SPQ_ASSERT_IMP(a_empty_flag, r_tvalid, o_m_tuser[1] == (r_count == '0),
        "empty flag disagrees with fill count")

endmodule

FILE: test/stable_min_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// Testbench for stable_min_priority_queue_top: insert/extract request beats with
// bursty input and a stalling receiver, each result beat checked against a sorted-list model.
// Depends on spq_pkg and the queue RTL.
module stable_min_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int NumItems    = 1750;
    localparam int DirectedLen = 22;
    localparam int HoldCycles  = 80;

    typedef struct {
        logic             kind;
        logic [DataW-1:0] value;
        logic [PrioW-1:0] prio;
        bit               wait_idle;
    } t_request;

    typedef struct {
        logic             taken;
        logic [DataW-1:0] taken_value;
        logic [PrioW-1:0] taken_prio;
        logic [DataW-1:0] head_value;
        logic [PrioW-1:0] head_prio;
        logic             empty;
        logic             dropped;
    } t_outcome;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [63:0]  s_tdata  = '0;  // [31:0] in_value, [63:32] in_priority
    logic         s_tuser  = 1'b0; // [0] req_type
    logic         o_m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] o_m_tdata;      // [31:0] out_value, [63:32] out_priority,
                                  // [95:64] head_value, [127:96] head_priority
    logic [2:0]   o_m_tuser;      // [0] out_valid, [1] queue_empty, [2] full_drop

    t_request req_backlog[$];
    t_outcome due_results[$];
    t_entry   held_entries[$];
    t_request on_bus;
    int       gen_fill     = 0;
    int       errors       = 0;
    int       results_seen = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       hold_left    = 0;
    int       holds_done   = 0;
    logic [31:0] rx_cycle  = '0;

    stable_min_priority_queue_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stable sorted insert, pop from head; result reflects the queue after the step.
    function automatic t_outcome apply_request(t_request rq);
        t_outcome r;
        t_entry   e;
        int       pos;
        r = '{default: '0};
        if (rq.kind == ReqInsert) begin
            if (held_entries.size() >= Depth) begin
                r.dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].prio <= rq.prio)
                    pos++;
                e.value = rq.value;
                e.prio  = rq.prio;
                held_entries.insert(pos, e);
            end
        end else if (held_entries.size() > 0) begin
            e = held_entries.pop_front();
            r.taken       = 1'b1;
            r.taken_value = e.value;
            r.taken_prio  = e.prio;
        end
        r.empty = (held_entries.size() == 0);
        if (!r.empty) begin
            r.head_value = held_entries[0].value;
            r.head_prio  = held_entries[0].prio;
        end
        return r;
    endfunction

    function automatic logic [PrioW-1:0] pick_prio(int mode);
        case (mode)
            0: return $urandom_range(0, 7);
            1: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 1;
                    2: return {PrioW{1'b1}} - 1'b1;
                    default: return {PrioW{1'b1}};
                endcase
            end
        endcase
    endfunction

    function automatic void add_request(logic kind, logic [DataW-1:0] value,
                                        logic [PrioW-1:0] prio);
        t_request rq;
        rq.kind      = kind;
        rq.value     = value;
        rq.prio      = prio;
        rq.wait_idle = (req_backlog.size() == DirectedLen) ||
                       (req_backlog.size() == NumItems / 2);
        req_backlog.push_back(rq);
        if (kind == ReqInsert && gen_fill < Depth)
            gen_fill++;
        else if (kind == ReqExtract && gen_fill > 0)
            gen_fill--;
    endfunction

    task automatic report_error(string msg);
        errors++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s on result %0d: got %h, expected %h",
                                   what, results_seen, got, want));
    endtask

    // request side
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && o_s_tready) begin
                due_results.push_back(apply_request(on_bus));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_backlog.size() > 0 &&
                             !(req_backlog[0].wait_idle && due_results.size() != 0)) begin
                    on_bus = req_backlog.pop_front();
                    s_tdata <= {on_bus.prio, on_bus.value};
                    s_tuser <= on_bus.kind;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_error("result beat with nothing expected");
                end else begin
                    want = due_results.pop_front();
                    check_field("out_valid",     32'(o_m_tuser[0]), 32'(want.taken));
                    check_field("out_value",     o_m_tdata[31:0],   want.taken_value);
                    check_field("out_priority",  o_m_tdata[63:32],  want.taken_prio);
                    check_field("head_value",    o_m_tdata[95:64],  want.head_value);
                    check_field("head_priority", o_m_tdata[127:96], want.head_prio);
                    check_field("queue_empty",   32'(o_m_tuser[1]), 32'(want.empty));
                    check_field("full_drop",     32'(o_m_tuser[2]), 32'(want.dropped));
                end
                results_seen++;
            end
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_done < 2 &&
                         results_seen >= ((holds_done == 0) ? 400 : 1300)) begin
                // long back-pressure: input side must stall
                hold_left = HoldCycles;
                holds_done++;
                m_tready <= 1'b0;
            end else begin
                case (rx_cycle[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (rx_cycle[1:0] != 2'd3);
                endcase
            end
        end
    end

    initial begin
        int pmode;
        int lean;
        // empty extract, extremes, ties at head and tail, fill up, overflow
        add_request(ReqExtract, $urandom, $urandom);
        add_request(ReqInsert, '0, '0);
        add_request(ReqInsert, {DataW{1'b1}}, {PrioW{1'b1}});
        add_request(ReqInsert, 32'h11, 32'd5);
        add_request(ReqInsert, 32'h22, 32'd5);
        add_request(ReqInsert, 32'h33, 32'd5);
        add_request(ReqInsert, 32'hA5A5_A5A5, '0);
        add_request(ReqInsert, 32'h5A5A_5A5A, {PrioW{1'b1}});
        while (gen_fill < Depth)
            add_request(ReqInsert, $urandom, $urandom_range(0, 9));
        add_request(ReqInsert, $urandom, $urandom);
        repeat (4) add_request(ReqExtract, $urandom, $urandom);

        while (req_backlog.size() < NumItems) begin
            pmode = $urandom_range(0, 2);
            case ($urandom_range(0, 4))
                0: begin
                    while (gen_fill < Depth)
                        add_request(ReqInsert, $urandom, pick_prio(pmode));
                    repeat ($urandom_range(1, 3))
                        add_request(ReqInsert, $urandom, pick_prio(pmode));
                    while (gen_fill > 0)
                        add_request(ReqExtract, $urandom, $urandom);
                    add_request(ReqExtract, $urandom, $urandom);
                end
                4: begin
                    repeat (8) add_request(1'($urandom_range(0, 1)), $urandom, $urandom);
                end
                default: begin
                    repeat (40) begin
                        lean = (gen_fill < 4) ? 3 : ((gen_fill > 12) ? 1 : 2);
                        add_request(($urandom_range(0, 3) < lean) ? ReqInsert : ReqExtract,
                                    $urandom, pick_prio(pmode));
                    end
                end
            endcase
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (req_backlog.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_min_priority_queue_top.sv
test/stable_min_priority_queue_top_tb.sv
